// ===== rtl/sps_pkg.sv =====
package sps_pkg;

  localparam int unsigned DEF_MAX_POC_CYCLE = 255;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Parse phases, in standard SPS order.
  localparam logic [5:0] P_HDR = 6'd0;
  localparam logic [5:0] P_PROFILE = 6'd1;
  localparam logic [5:0] P_FLAGS = 6'd2;
  localparam logic [5:0] P_LEVEL = 6'd3;
  localparam logic [5:0] P_SPSID = 6'd4;
  localparam logic [5:0] P_CHROMA = 6'd5;
  localparam logic [5:0] P_SEPCOL = 6'd6;
  localparam logic [5:0] P_LUMA = 6'd7;
  localparam logic [5:0] P_CDEPTH = 6'd8;
  localparam logic [5:0] P_BYPASS = 6'd9;
  localparam logic [5:0] P_SMFLAG = 6'd10;
  localparam logic [5:0] P_LISTFLAG = 6'd11;
  localparam logic [5:0] P_DELTA = 6'd12;
  localparam logic [5:0] P_LOG2FN = 6'd13;
  localparam logic [5:0] P_POCTYPE = 6'd14;
  localparam logic [5:0] P_POCLSB = 6'd15;
  localparam logic [5:0] P_DELTAZERO = 6'd16;
  localparam logic [5:0] P_OFFNONREF = 6'd17;
  localparam logic [5:0] P_OFFTB = 6'd18;
  localparam logic [5:0] P_NCYCLE = 6'd19;
  localparam logic [5:0] P_CYCOFF = 6'd20;
  localparam logic [5:0] P_MAXREF = 6'd21;
  localparam logic [5:0] P_GAPS = 6'd22;
  localparam logic [5:0] P_WMBS = 6'd23;
  localparam logic [5:0] P_HMAP = 6'd24;
  localparam logic [5:0] P_FMO = 6'd25;
  localparam logic [5:0] P_MBAFF = 6'd26;
  localparam logic [5:0] P_D8X8 = 6'd27;
  localparam logic [5:0] P_CROPFLAG = 6'd28;
  localparam logic [5:0] P_CROPL = 6'd29;
  localparam logic [5:0] P_CROPR = 6'd30;
  localparam logic [5:0] P_CROPT = 6'd31;
  localparam logic [5:0] P_CROPB = 6'd32;
  localparam logic [5:0] P_VUIFLAG = 6'd33;
  localparam logic [5:0] P_ARFLAG = 6'd34;
  localparam logic [5:0] P_ARIDC = 6'd35;
  localparam logic [5:0] P_SAR = 6'd36;
  localparam logic [5:0] P_OVFLAG = 6'd37;
  localparam logic [5:0] P_OVAPP = 6'd38;
  localparam logic [5:0] P_VSFLAG = 6'd39;
  localparam logic [5:0] P_VSBITS = 6'd40;
  localparam logic [5:0] P_CDFLAG = 6'd41;
  localparam logic [5:0] P_CDBITS = 6'd42;
  localparam logic [5:0] P_CLFLAG = 6'd43;
  localparam logic [5:0] P_CL0 = 6'd44;
  localparam logic [5:0] P_CL1 = 6'd45;
  localparam logic [5:0] P_TIMFLAG = 6'd46;
  localparam logic [5:0] P_UNITS = 6'd47;
  localparam logic [5:0] P_SCALE = 6'd48;
  localparam logic [5:0] P_DONE = 6'd49;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
  } qitem_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_BITS,
    BS_WIDTH,
    BS_HEIGHT,
    BS_EMIT
  } back_state_t;

  // Bits of a fixed-length phase; zero marks an exp-Golomb phase.
  function automatic logic [5:0] phase_width(input logic [5:0] ph);
    logic [5:0] w;
    w = 6'd0;
    case (ph)
      P_HDR, P_PROFILE, P_FLAGS, P_LEVEL, P_ARIDC: w = 6'd8;
      P_SEPCOL, P_BYPASS, P_SMFLAG, P_LISTFLAG, P_DELTAZERO, P_GAPS,
      P_FMO, P_MBAFF, P_D8X8, P_CROPFLAG, P_VUIFLAG, P_ARFLAG,
      P_OVFLAG, P_OVAPP, P_VSFLAG, P_CDFLAG, P_CLFLAG, P_TIMFLAG: w = 6'd1;
      P_SAR, P_UNITS, P_SCALE: w = 6'd32;
      P_VSBITS: w = 6'd4;
      P_CDBITS: w = 6'd24;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
           p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
           p == 8'd135;
  endfunction

endpackage

// ===== rtl/sps_in_if.sv =====
interface sps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] nal_byte;
  logic       last_byte;

  modport source(output valid, nal_byte, last_byte, input ready);
  modport sink(input valid, nal_byte, last_byte, output ready);
endinterface

// ===== rtl/sps_out_if.sv =====
interface sps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  profile;
  logic [7:0]  constraint_flags;
  logic [7:0]  level;
  logic [4:0]  set_id;
  logic [1:0]  chroma_format;
  logic [3:0]  luma_depth;
  logic [3:0]  chroma_depth;
  logic [15:0] pic_width;
  logic [15:0] pic_height;
  logic [31:0] tick_units;
  logic [31:0] tick_scale;
  logic [1:0]  status;

  modport source(output valid, profile, constraint_flags, level, set_id, chroma_format,
                 luma_depth, chroma_depth, pic_width, pic_height, tick_units,
                 tick_scale, status, input ready);
  modport sink(input valid, profile, constraint_flags, level, set_id, chroma_format,
               luma_depth, chroma_depth, pic_width, pic_height, tick_units,
               tick_scale, status, output ready);
endinterface

// ===== rtl/sps_fifo.sv =====
module sps_fifo import sps_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   avail,
  output qitem_t head
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qitem_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end
endmodule

// ===== rtl/sps_front.sv =====
module sps_front import sps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  sps_in_if.sink   nal,
  input  logic     q_full,
  output logic     q_push,
  output qitem_t   q_item
);
  logic [1:0] zero_run;
  logic       drop;

  // A 0x03 after two zero bytes is emulation prevention and carries no bits.
  assign drop      = zero_run == 2'd2 && nal.nal_byte == 8'h03;
  assign nal.ready = !q_full;
  assign q_push    = nal.valid && !q_full;
  assign q_item    = '{data: nal.nal_byte, last: nal.last_byte, drop: drop};

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run <= '0;
    end else if (q_push) begin
      // A new unit starts with a clean run count.
      if (nal.last_byte || drop || nal.nal_byte != 8'h00) begin
        zero_run <= '0;
      end else if (zero_run != 2'd2) begin
        zero_run <= zero_run + 1'b1;
      end
    end
  end
endmodule

// ===== rtl/sps_back.sv =====
module sps_back import sps_pkg::*; #(
  parameter int unsigned MAX_POC_CYCLE = DEF_MAX_POC_CYCLE
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_avail,
  input  qitem_t    q_head,
  output logic      q_pop,
  sps_out_if.source res
);
  back_state_t state, state_next;

  logic [7:0]  shreg;
  logic [2:0]  bit_cnt;
  logic        cur_last;
  logic        do_bit, out_load, clear;

  logic [5:0]  phase;
  logic [32:0] acc;
  logic [5:0]  lz;
  logic [3:0]  list_index;
  logic [6:0]  entry_index;
  logic [7:0]  prev_scale;
  logic [7:0]  next_scale_reg;
  logic [7:0]  cycle_remaining;

  logic [7:0]  f_profile, f_flags, f_level;
  logic [4:0]  f_setid;
  logic [2:0]  f_chroma;
  logic [3:0]  f_luma, f_cdepth;
  logic        f_fmo, f_timing;
  logic [31:0] wmbs, hmap, crop_x, crop_y, units, scale;

  logic [15:0] wv, hv;
  logic        size_bad;

  // Bit-serial reader.
  logic        b, fd;
  logic [5:0]  w;
  logic [32:0] acc_n;
  logic [5:0]  lz_n;
  logic [31:0] v;
  logic [33:0] dbl;

  always_comb begin
    b     = shreg[7];
    w     = phase_width(phase);
    fd    = 1'b0;
    acc_n = acc;
    lz_n  = lz;
    v     = '0;
    dbl   = {acc, b};
    if (phase < P_DONE) begin
      if (w != 6'd0) begin
        acc_n = {acc[31:0], b};
        lz_n  = lz + 1'b1;
        if (lz_n >= w) begin
          fd = 1'b1;
          v  = acc_n[31:0];
        end
      end else if (acc == '0) begin
        if (!b) begin
          if (lz != 6'd63) lz_n = lz + 1'b1;
        end else begin
          acc_n = 33'd1;
          fd    = lz == 6'd0;
        end
      end else begin
        acc_n = (dbl > 34'h1_0000_0000) ? 33'h1_0000_0000 : dbl[32:0];
        lz_n  = lz - 1'b1;
        if (lz_n == 6'd0) begin
          fd = 1'b1;
          v  = 32'(acc_n - 33'd1);
        end
      end
      if (fd) begin
        acc_n = '0;
        lz_n  = '0;
      end
    end
  end

  // Field completion helpers.
  logic [3:0]  list_inc;
  logic [5:0]  list_phase;
  logic [7:0]  dk, dval, ns;
  logic [6:0]  ei_n;
  logic [32:0] sum_x, sum_y;
  logic [31:0] sat_x, sat_y;

  always_comb begin
    list_inc   = list_index + 1'b1;
    list_phase = (list_inc >= ((f_chroma == 3'd3) ? 4'd12 : 4'd8)) ? P_LOG2FN : P_LISTFLAG;
    dk         = v[8:1];
    dval       = v[0] ? dk + 8'd1 : 8'd0 - dk;
    ns         = prev_scale + dval;
    ei_n       = entry_index + 1'b1;
    sum_x      = {1'b0, crop_x} + {1'b0, v};
    sum_y      = {1'b0, crop_y} + {1'b0, v};
    sat_x      = sum_x[32] ? SAT32 : sum_x[31:0];
    sat_y      = sum_y[32] ? SAT32 : sum_y[31:0];
  end

  // Crop arithmetic, one dimension per cycle.
  logic [36:0] full_w, cut_w;
  logic [37:0] full_h, cut_h;
  logic [1:0]  hshift;
  logic        subw2, subh2;

  always_comb begin
    subw2  = !(f_chroma == 3'd3 || f_chroma == 3'd0);
    subh2  = f_chroma == 3'd1;
    hshift = 2'(subh2) + 2'(!f_fmo);
    full_w = {({1'b0, wmbs} + 33'd1), 4'd0};
    cut_w  = subw2 ? 37'({crop_x, 1'b0}) : 37'(crop_x);
    full_h = f_fmo ? 38'({({1'b0, hmap} + 33'd1), 4'd0})
                   : {({1'b0, hmap} + 33'd1), 5'd0};
    cut_h  = 38'(crop_y) << hshift;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (q_avail) begin
          if (!q_head.drop) state_next = BS_BITS;
          else if (q_head.last) state_next = BS_WIDTH;
        end
      end
      BS_BITS: begin
        if (bit_cnt == 3'd7) state_next = cur_last ? BS_WIDTH : BS_IDLE;
      end
      BS_WIDTH: state_next = BS_HEIGHT;
      BS_HEIGHT: state_next = BS_EMIT;
      BS_EMIT: begin
        if (!res.valid || res.ready) state_next = BS_IDLE;
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    do_bit   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      BS_IDLE: q_pop = q_avail;
      BS_BITS: do_bit = 1'b1;
      BS_EMIT: out_load = !res.valid || res.ready;
      default: ;
    endcase
  end

  assign clear = rst || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shreg    <= q_head.data;
      cur_last <= q_head.last;
      bit_cnt  <= '0;
    end else if (do_bit) begin
      shreg   <= {shreg[6:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      phase           <= P_HDR;
      acc             <= '0;
      lz              <= '0;
      list_index      <= '0;
      entry_index     <= '0;
      prev_scale      <= 8'd8;
      next_scale_reg  <= 8'd8;
      cycle_remaining <= '0;
      f_profile       <= '0;
      f_flags         <= '0;
      f_level         <= '0;
      f_setid         <= '0;
      f_chroma        <= 3'd1;
      f_luma          <= 4'd8;
      f_cdepth        <= 4'd8;
      f_fmo           <= 1'b0;
      f_timing        <= 1'b0;
      wmbs            <= '0;
      hmap            <= '0;
      crop_x          <= '0;
      crop_y          <= '0;
      units           <= '0;
      scale           <= '0;
    end else if (do_bit) begin
      acc <= acc_n;
      lz  <= lz_n;
      if (fd) begin
        case (phase)
          P_HDR: phase <= P_PROFILE;
          P_PROFILE: begin f_profile <= v[7:0]; phase <= P_FLAGS; end
          P_FLAGS: begin f_flags <= v[7:0]; phase <= P_LEVEL; end
          P_LEVEL: begin f_level <= v[7:0]; phase <= P_SPSID; end
          P_SPSID: begin
            f_setid <= (v > 32'd31) ? 5'd31 : v[4:0];
            phase   <= high_profile(f_profile) ? P_CHROMA : P_LOG2FN;
          end
          P_CHROMA: begin
            f_chroma <= (v > 32'd4) ? 3'd4 : v[2:0];
            phase    <= (v == 32'd3) ? P_SEPCOL : P_LUMA;
          end
          P_SEPCOL: phase <= P_LUMA;
          P_LUMA: begin
            f_luma <= (v > 32'd7) ? 4'd15 : v[3:0] + 4'd8;
            phase  <= P_CDEPTH;
          end
          P_CDEPTH: begin
            f_cdepth <= (v > 32'd7) ? 4'd15 : v[3:0] + 4'd8;
            phase    <= P_BYPASS;
          end
          P_BYPASS: phase <= P_SMFLAG;
          P_SMFLAG: begin
            if (v[0]) begin
              list_index <= '0;
              phase      <= P_LISTFLAG;
            end else begin
              phase <= P_LOG2FN;
            end
          end
          P_LISTFLAG: begin
            if (v[0]) begin
              entry_index    <= '0;
              prev_scale     <= 8'd8;
              next_scale_reg <= 8'd8;
              phase          <= P_DELTA;
            end else begin
              list_index <= list_inc;
              phase      <= list_phase;
            end
          end
          P_DELTA: begin
            next_scale_reg <= ns;
            if (ns != 8'd0) prev_scale <= ns;
            entry_index <= ei_n;
            if (ns == 8'd0 || ei_n >= ((list_index < 4'd6) ? 7'd16 : 7'd64)) begin
              list_index <= list_inc;
              phase      <= list_phase;
            end
          end
          P_LOG2FN: phase <= P_POCTYPE;
          P_POCTYPE: begin
            if (v == 32'd0) phase <= P_POCLSB;
            else if (v == 32'd1) phase <= P_DELTAZERO;
            else phase <= P_MAXREF;
          end
          P_POCLSB: phase <= P_MAXREF;
          P_DELTAZERO: phase <= P_OFFNONREF;
          P_OFFNONREF: phase <= P_OFFTB;
          P_OFFTB: phase <= P_NCYCLE;
          P_NCYCLE: begin
            if (v > 32'(MAX_POC_CYCLE)) begin
              cycle_remaining <= 8'(MAX_POC_CYCLE);
              phase           <= P_CYCOFF;
            end else begin
              cycle_remaining <= v[7:0];
              phase           <= (v == 32'd0) ? P_MAXREF : P_CYCOFF;
            end
          end
          P_CYCOFF: begin
            cycle_remaining <= cycle_remaining - 1'b1;
            if (cycle_remaining == 8'd1) phase <= P_MAXREF;
          end
          P_MAXREF: phase <= P_GAPS;
          P_GAPS: phase <= P_WMBS;
          P_WMBS: begin wmbs <= v; phase <= P_HMAP; end
          P_HMAP: begin hmap <= v; phase <= P_FMO; end
          P_FMO: begin f_fmo <= v[0]; phase <= v[0] ? P_D8X8 : P_MBAFF; end
          P_MBAFF: phase <= P_D8X8;
          P_D8X8: phase <= P_CROPFLAG;
          P_CROPFLAG: phase <= v[0] ? P_CROPL : P_VUIFLAG;
          P_CROPL, P_CROPR: begin crop_x <= sat_x; phase <= phase + 1'b1; end
          P_CROPT, P_CROPB: begin crop_y <= sat_y; phase <= phase + 1'b1; end
          P_VUIFLAG: phase <= v[0] ? P_ARFLAG : P_DONE;
          P_ARFLAG: phase <= v[0] ? P_ARIDC : P_OVFLAG;
          P_ARIDC: phase <= (v == 32'd255) ? P_SAR : P_OVFLAG;
          P_SAR: phase <= P_OVFLAG;
          P_OVFLAG: phase <= v[0] ? P_OVAPP : P_VSFLAG;
          P_OVAPP: phase <= P_VSFLAG;
          P_VSFLAG: phase <= v[0] ? P_VSBITS : P_CLFLAG;
          P_VSBITS: phase <= P_CDFLAG;
          P_CDFLAG: phase <= v[0] ? P_CDBITS : P_CLFLAG;
          P_CDBITS: phase <= P_CLFLAG;
          P_CLFLAG: phase <= v[0] ? P_CL0 : P_TIMFLAG;
          P_CL0: phase <= P_CL1;
          P_CL1: phase <= P_TIMFLAG;
          P_TIMFLAG: phase <= v[0] ? P_UNITS : P_DONE;
          P_UNITS: begin units <= v; phase <= P_SCALE; end
          P_SCALE: begin scale <= v; f_timing <= 1'b1; phase <= P_DONE; end
          default: phase <= P_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_WIDTH) begin
      size_bad <= crop_x == SAT32 || crop_y == SAT32 || cut_w > full_w ||
                  (full_w - cut_w) > 37'd65535;
      wv <= 16'(full_w - cut_w);
    end else if (state == BS_HEIGHT) begin
      if (cut_h > full_h || (full_h - cut_h) > 38'd65535) size_bad <= 1'b1;
      hv <= 16'(full_h - cut_h);
    end
  end

  logic empty_unit, trunc_unit;
  assign empty_unit = phase == P_PROFILE && lz == 6'd0 && acc == '0;
  assign trunc_unit = phase < P_ARFLAG;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (empty_unit || trunc_unit) begin
        res.profile          <= '0;
        res.constraint_flags <= '0;
        res.level            <= '0;
        res.set_id           <= '0;
        res.chroma_format    <= '0;
        res.luma_depth       <= '0;
        res.chroma_depth     <= '0;
        res.pic_width        <= '0;
        res.pic_height       <= '0;
        res.tick_units       <= '0;
        res.tick_scale       <= '0;
        res.status           <= empty_unit ? ST_EMPTY : ST_TRUNC;
      end else begin
        res.profile          <= f_profile;
        res.constraint_flags <= f_flags;
        res.level            <= f_level;
        res.set_id           <= f_setid;
        res.chroma_format    <= (f_chroma > 3'd3) ? 2'd3 : f_chroma[1:0];
        res.luma_depth       <= f_luma;
        res.chroma_depth     <= f_cdepth;
        res.pic_width        <= size_bad ? 16'd0 : wv;
        res.pic_height       <= size_bad ? 16'd0 : hv;
        res.tick_units       <= f_timing ? units : 32'd0;
        res.tick_scale       <= f_timing ? scale : 32'd0;
        res.status           <= size_bad ? ST_RANGE : ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_bits: assert property (@(posedge clk) disable iff (rst)
    (state == BS_IDLE && q_avail && !q_head.drop) |=> state == BS_BITS)
    else $error("kept byte did not enter bit walk");
  a_byte_end: assert property (@(posedge clk) disable iff (rst)
    (state == BS_BITS && bit_cnt == 3'd7 && !cur_last) |=> state == BS_IDLE)
    else $error("non-final byte did not return to idle");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= P_DONE)
    else $error("parse phase beyond done");
  a_unit_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (phase == P_HDR && lz == 6'd0 && acc == '0 && res.valid))
    else $error("unit state not cleared after result");
`endif
endmodule

// ===== rtl/h264_sps_header_parser.sv =====
// Channel  Dir  Payload                                         Beat
// nal      in   nal_byte, last_byte                             valid & ready
// res      out  profile..tick_scale, status (one per unit)      valid & ready
//
// The back end pops each kept byte and feeds it to the bit-serial reader for
// fixed-length and exp-Golomb fields, one bit per cycle. The last byte leads to
// the width and height crop checks, then the result load once res is free.
// A dropped emulation byte skips the bit walk. The two-entry queue takes input
// beats while the reader is busy; the result register holds until taken.
// Reset is synchronous and clears all control and parse state.
module h264_sps_header_parser import sps_pkg::*; #(
  parameter int unsigned MAX_POC_CYCLE = DEF_MAX_POC_CYCLE
) (
  input logic       clk,
  input logic       rst,
  sps_in_if.sink    nal,
  sps_out_if.source res
);
  logic   q_full, q_push, q_pop, q_avail;
  qitem_t q_in, q_head;

  sps_front u_front (
    .clk    (clk),
    .rst    (rst),
    .nal    (nal),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  sps_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  sps_back #(.MAX_POC_CYCLE(MAX_POC_CYCLE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );
endmodule

// ===== tb/sv/sps_result_checker.sv =====
module sps_result_checker import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  sps_in_if    nal,
  sps_out_if   res,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  profile;
    logic [7:0]  constraint_flags;
    logic [7:0]  level;
    logic [4:0]  set_id;
    logic [1:0]  chroma_format;
    logic [3:0]  luma_depth;
    logic [3:0]  chroma_depth;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [31:0] tick_units;
    logic [31:0] tick_scale;
    logic [1:0]  status;
  } sps_summary_t;

  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

  sps_summary_t summary_q[$];

  // Shadow of the parser state.
  logic [5:0]  phase;
  logic [1:0]  zrun;
  logic [63:0] acc;
  logic [5:0]  lz;
  logic [3:0]  lidx;
  logic [6:0]  eidx;
  logic [7:0]  prev_sc, next_sc;
  logic [7:0]  cyc_left;
  logic [7:0]  f_profile, f_flags, f_level;
  logic [4:0]  f_setid;
  logic [2:0]  f_chroma;
  logic [3:0]  f_luma, f_cdepth;
  logic        f_fmo, f_timing;
  logic [63:0] w_mbs, h_map, crop_x, crop_y, units, scale;
  logic        in_unit;

  function automatic int field_bits(logic [5:0] ph);
    case (ph)
      P_HDR, P_PROFILE, P_FLAGS, P_LEVEL, P_ARIDC: return 8;
      P_SEPCOL, P_BYPASS, P_SMFLAG, P_LISTFLAG, P_DELTAZERO, P_GAPS, P_FMO,
      P_MBAFF, P_D8X8, P_CROPFLAG, P_VUIFLAG, P_ARFLAG, P_OVFLAG, P_OVAPP,
      P_VSFLAG, P_CDFLAG, P_CLFLAG, P_TIMFLAG: return 1;
      P_SAR, P_UNITS, P_SCALE: return 32;
      P_VSBITS: return 4;
      P_CDBITS: return 24;
      default: return 0;
    endcase
  endfunction

  function automatic bit is_high(logic [7:0] p);
    case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
      8'd138, 8'd139, 8'd134, 8'd135: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > MASK32) ? MASK32 : s;
  endfunction

  task automatic clear_unit();
    phase = P_HDR; zrun = 0; acc = 0; lz = 0; lidx = 0; eidx = 0;
    prev_sc = 8; next_sc = 8; cyc_left = 0;
    f_profile = 0; f_flags = 0; f_level = 0; f_setid = 0;
    f_chroma = 1; f_luma = 8; f_cdepth = 8; f_fmo = 0; f_timing = 0;
    w_mbs = 0; h_map = 0; crop_x = 0; crop_y = 0; units = 0; scale = 0;
  endtask

  task automatic next_list(int i);
    int cnt;
    cnt = (f_chroma == 3) ? 12 : 8;
    lidx = 4'(i);
    phase = (i >= cnt) ? P_LOG2FN : P_LISTFLAG;
  endtask

  task automatic finish_field(logic [5:0] ph, logic [63:0] v);
    logic [63:0] d;
    case (ph)
      P_HDR: phase = P_PROFILE;
      P_PROFILE: begin f_profile = v[7:0]; phase = P_FLAGS; end
      P_FLAGS: begin f_flags = v[7:0]; phase = P_LEVEL; end
      P_LEVEL: begin f_level = v[7:0]; phase = P_SPSID; end
      P_SPSID: begin
        f_setid = (v > 31) ? 5'd31 : v[4:0];
        phase = is_high(f_profile) ? P_CHROMA : P_LOG2FN;
      end
      P_CHROMA: begin
        f_chroma = (v > 4) ? 3'd4 : v[2:0];
        phase = (v == 3) ? P_SEPCOL : P_LUMA;
      end
      P_SEPCOL: phase = P_LUMA;
      P_LUMA: begin f_luma = (v > 7) ? 4'd15 : v[3:0] + 4'd8; phase = P_CDEPTH; end
      P_CDEPTH: begin f_cdepth = (v > 7) ? 4'd15 : v[3:0] + 4'd8; phase = P_BYPASS; end
      P_BYPASS: phase = P_SMFLAG;
      P_SMFLAG: if (v != 0) next_list(0); else phase = P_LOG2FN;
      P_LISTFLAG: begin
        if (v != 0) begin
          eidx = 0; prev_sc = 8; next_sc = 8; phase = P_DELTA;
        end else next_list(lidx + 1);
      end
      P_DELTA: begin
        // Odd codes map to positive deltas, even ones to zero or negative.
        d = v[0] ? ((v + 1) >> 1) : (64'd0 - (v >> 1));
        next_sc = prev_sc + d[7:0];
        if (next_sc != 0) prev_sc = next_sc;
        eidx = eidx + 7'd1;
        if (next_sc == 0 || eidx >= ((lidx < 6) ? 16 : 64)) next_list(lidx + 1);
      end
      P_LOG2FN: phase = P_POCTYPE;
      P_POCTYPE: phase = (v == 0) ? P_POCLSB : (v == 1) ? P_DELTAZERO : P_MAXREF;
      P_POCLSB: phase = P_MAXREF;
      P_DELTAZERO: phase = P_OFFNONREF;
      P_OFFNONREF: phase = P_OFFTB;
      P_OFFTB: phase = P_NCYCLE;
      P_NCYCLE: begin
        cyc_left = (v > DEF_MAX_POC_CYCLE) ? 8'(DEF_MAX_POC_CYCLE) : v[7:0];
        phase = (cyc_left != 0) ? P_CYCOFF : P_MAXREF;
      end
      P_CYCOFF: begin
        cyc_left = cyc_left - 8'd1;
        if (cyc_left == 0) phase = P_MAXREF;
      end
      P_MAXREF: phase = P_GAPS;
      P_GAPS: phase = P_WMBS;
      P_WMBS: begin w_mbs = v; phase = P_HMAP; end
      P_HMAP: begin h_map = v; phase = P_FMO; end
      P_FMO: begin f_fmo = v[0]; phase = v[0] ? P_D8X8 : P_MBAFF; end
      P_MBAFF: phase = P_D8X8;
      P_D8X8: phase = P_CROPFLAG;
      P_CROPFLAG: phase = (v != 0) ? P_CROPL : P_VUIFLAG;
      P_CROPL, P_CROPR: begin crop_x = add_sat(crop_x, v); phase = ph + 6'd1; end
      P_CROPT, P_CROPB: begin crop_y = add_sat(crop_y, v); phase = ph + 6'd1; end
      P_VUIFLAG: phase = (v != 0) ? P_ARFLAG : P_DONE;
      P_ARFLAG: phase = (v != 0) ? P_ARIDC : P_OVFLAG;
      P_ARIDC: phase = (v == 255) ? P_SAR : P_OVFLAG;
      P_SAR: phase = P_OVFLAG;
      P_OVFLAG: phase = (v != 0) ? P_OVAPP : P_VSFLAG;
      P_OVAPP: phase = P_VSFLAG;
      P_VSFLAG: phase = (v != 0) ? P_VSBITS : P_CLFLAG;
      P_VSBITS: phase = P_CDFLAG;
      P_CDFLAG: phase = (v != 0) ? P_CDBITS : P_CLFLAG;
      P_CDBITS: phase = P_CLFLAG;
      P_CLFLAG: phase = (v != 0) ? P_CL0 : P_TIMFLAG;
      P_CL0: phase = P_CL1;
      P_CL1: phase = P_TIMFLAG;
      P_TIMFLAG: phase = (v != 0) ? P_UNITS : P_DONE;
      P_UNITS: begin units = v; phase = P_SCALE; end
      P_SCALE: begin scale = v; f_timing = 1; phase = P_DONE; end
      default: phase = P_DONE;
    endcase
  endtask

  task automatic shift_in_bit(bit b);
    logic [5:0]  ph;
    int          w;
    logic [63:0] v;
    ph = phase;
    if (ph >= P_DONE) return;
    w = field_bits(ph);
    if (w != 0) begin
      acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
      lz = lz + 6'd1;
      if (lz < w) return;
      v = acc & MASK32;
    end else if (acc == 0) begin
      if (!b) begin
        if (lz < 63) lz = lz + 6'd1;
        return;
      end
      acc = 1;
      if (lz != 0) return;
      v = 0;
    end else begin
      acc = acc * 2 + b;
      if (acc > 64'h1_0000_0000) acc = 64'h1_0000_0000;
      lz = lz - 6'd1;
      if (lz != 0) return;
      v = acc - 1;
    end
    acc = 0;
    lz = 0;
    finish_field(ph, v);
  endtask

  task automatic take_byte(logic [7:0] data, logic last);
    sps_summary_t r;
    int          subw, subh, fm;
    logic [63:0] full, cut, wv, hv;
    logic [1:0]  st;
    if (!in_unit) begin
      clear_unit();
      in_unit = 1;
    end
    if (zrun >= 2 && data == 8'h03) zrun = 0;
    else begin
      zrun = (data != 0) ? 2'd0 : ((zrun >= 2) ? 2'd2 : zrun + 2'd1);
      for (int i = 7; i >= 0; i--) shift_in_bit(data[i]);
    end
    if (!last) return;
    in_unit = 0;
    r = '0;
    if (phase == P_PROFILE && lz == 0 && acc == 0) begin
      r.status = ST_EMPTY;
    end else if (phase < P_ARFLAG) begin
      r.status = ST_TRUNC;
    end else begin
      st = ST_OK; wv = 0; hv = 0;
      subw = (f_chroma == 3) ? 1 : 2;
      subh = (f_chroma == 1) ? 2 : 1;
      if (f_chroma == 0) begin subw = 1; subh = 1; end
      fm = f_fmo ? 1 : 2;
      if (crop_x == MASK32 || crop_y == MASK32) st = ST_RANGE;
      full = (w_mbs + 1) * 16;
      cut = crop_x * subw;
      if (cut > full || full - cut > 65535) st = ST_RANGE; else wv = full - cut;
      full = (h_map + 1) * 16 * fm;
      cut = crop_y * subh * fm;
      if (cut > full || full - cut > 65535) st = ST_RANGE; else hv = full - cut;
      r.profile = f_profile;
      r.constraint_flags = f_flags;
      r.level = f_level;
      r.set_id = f_setid;
      r.chroma_format = (f_chroma > 3) ? 2'd3 : f_chroma[1:0];
      r.luma_depth = f_luma;
      r.chroma_depth = f_cdepth;
      r.pic_width = (st != ST_OK) ? 16'd0 : wv[15:0];
      r.pic_height = (st != ST_OK) ? 16'd0 : hv[15:0];
      if (f_timing) begin
        r.tick_units = units[31:0];
        r.tick_scale = scale[31:0];
      end
      r.status = st;
    end
    summary_q.insert(summary_q.size(), r);
  endtask

  sps_summary_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      in_unit = 0;
      errors = 0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{res.profile, res.constraint_flags, res.level, res.set_id,
                res.chroma_format, res.luma_depth, res.chroma_depth, res.pic_width,
                res.pic_height, res.tick_units, res.tick_scale, res.status};
        if (summary_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("%0t: result with none expected: %p", $realtime, got);
        end else begin
          want = summary_q.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (nal.valid && nal.ready) take_byte(nal.nal_byte, nal.last_byte);
    end
    pending = summary_q.size();
  end
endmodule

// ===== tb/sv/h264_sps_header_parser_tb.sv =====
module h264_sps_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BYTES = 1950;
  localparam int STALL_LIMIT = 10000;
  localparam int LONG_HOLD = 400;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  int   sent = 0;
  int   total = 0;
  int   quiet_from = 0;
  int   idle_cycles = 0;
  bit   long_hold_done = 0;

  bit         bit_q[$];
  logic [7:0] byte_q[$];
  bit         last_q[$];

  sps_in_if  nal_ch();
  sps_out_if res_ch();

  h264_sps_header_parser DUT (.clk(clk), .rst(rst), .nal(nal_ch), .res(res_ch));

  sps_result_checker u_checker (
    .clk(clk), .rst(rst), .nal(nal_ch), .res(res_ch), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task automatic put_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bit_q.insert(bit_q.size(), v[i]);
  endtask

  task automatic put_ue(logic [31:0] v);
    logic [32:0] x;
    int          n;
    x = {1'b0, v} + 33'd1;
    n = 0;
    for (int i = 0; i < 33; i++) if (x[i]) n = i + 1;
    put_bits(0, n - 1);
    put_bits({31'd0, x}, n);
  endtask

  task automatic put_se(int s);
    put_ue((s > 0) ? 2 * s - 1 : -2 * s);
  endtask

  function automatic logic [31:0] pick_code(int small_max);
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, small_max);
    endcase
  endfunction

  // Packs the bit stream into bytes, inserts emulation prevention and queues
  // the bytes, optionally cutting the unit short.
  task automatic emit_unit(bit cut_short);
    logic [7:0] raw[$];
    logic [7:0] b;
    int         zeros, keep;
    bit_q.insert(bit_q.size(), 1'b1);
    while (bit_q.size() % 8 != 0) bit_q.insert(bit_q.size(), 1'b0);
    while (bit_q.size() != 0) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], bit_q.pop_front()};
      raw.insert(raw.size(), b);
    end
    keep = cut_short ? $urandom_range(1, raw.size()) : raw.size();
    zeros = 0;
    for (int i = 0; i < keep; i++) begin
      if (zeros >= 2 && raw[i] <= 8'h03) begin
        byte_q.insert(byte_q.size(), 8'h03); last_q.insert(last_q.size(), 1'b0);
        zeros = 0;
      end
      byte_q.insert(byte_q.size(), raw[i]);
      last_q.insert(last_q.size(), i == keep - 1);
      zeros = (raw[i] == 0) ? zeros + 1 : 0;
    end
  endtask

  task automatic make_sps(bit force_full);
    logic [7:0] high_list[13] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139,
                                  134, 135};
    logic [7:0] prof;
    int         chroma, poc, ncyc, lists, size, prev, nxt, d;
    bit         hi, sm;
    put_bits($urandom_range(0, 255), 8);
    hi = force_full || ($urandom_range(0, 2) != 0);
    prof = hi ? high_list[$urandom_range(0, 12)] : $urandom_range(0, 255);
    put_bits(prof, 8);
    put_bits($urandom_range(0, 255), 8);
    put_bits($urandom_range(0, 255), 8);
    put_ue(pick_code(40));
    if (hi) begin
      chroma = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 5);
      put_ue(chroma);
      if (chroma == 3) put_bits($urandom_range(0, 1), 1);
      put_ue(pick_code(9));
      put_ue(pick_code(9));
      put_bits($urandom_range(0, 1), 1);
      sm = force_full || ($urandom_range(0, 2) == 0);
      put_bits(sm, 1);
      if (sm) begin
        lists = (chroma == 3) ? 12 : 8;
        for (int l = 0; l < lists; l++) begin
          if ($urandom_range(0, 2) == 0) begin
            put_bits(1, 1);
            size = (l < 6) ? 16 : 64;
            prev = 8;
            for (int j = 0; j < size; j++) begin
              d = ($urandom_range(0, 30) == 0) ? -prev : $urandom_range(0, 40) - 20;
              if ($urandom_range(0, 40) == 0) d = $urandom_range(100, 300);
              put_se(d);
              nxt = (prev + d) & 255;
              if (nxt == 0) break;
              prev = nxt;
            end
          end else put_bits(0, 1);
        end
      end
    end
    put_ue($urandom_range(0, 12));
    poc = $urandom_range(0, 3);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(0, 12));
    else if (poc == 1) begin
      put_bits($urandom_range(0, 1), 1);
      put_se($urandom_range(0, 200) - 100);
      put_se($urandom_range(0, 200) - 100);
      ncyc = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 5);
      put_ue(ncyc);
      for (int j = 0; j < ((ncyc > 255) ? 255 : ncyc); j++) put_se($urandom_range(0, 6) - 3);
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom_range(0, 1), 1);
    put_ue(pick_code(240));
    put_ue(pick_code(135));
    put_bits($urandom_range(0, 1), 1);
    if (bit_q[bit_q.size() - 1] == 0) put_bits($urandom_range(0, 1), 1);
    put_bits($urandom_range(0, 1), 1);
    if ($urandom_range(0, 1)) begin
      put_bits(1, 1);
      for (int j = 0; j < 4; j++) put_ue(($urandom_range(0, 9) == 0) ? pick_code(5000) :
                                          $urandom_range(0, 8));
    end else put_bits(0, 1);
    if (force_full || $urandom_range(0, 3) != 0) begin
      put_bits(1, 1);
      if ($urandom_range(0, 1)) begin
        put_bits(1, 1);
        if ($urandom_range(0, 1)) begin put_bits(255, 8); put_bits($urandom, 32); end
        else put_bits($urandom_range(0, 254), 8);
      end else put_bits(0, 1);
      if ($urandom_range(0, 1)) put_bits($urandom_range(2, 3), 2); else put_bits(0, 1);
      if ($urandom_range(0, 1)) begin
        put_bits(1, 1);
        put_bits($urandom_range(0, 15), 4);
        if ($urandom_range(0, 1)) begin put_bits(1, 1); put_bits($urandom, 24); end
        else put_bits(0, 1);
      end else put_bits(0, 1);
      if ($urandom_range(0, 1)) begin
        put_bits(1, 1); put_ue($urandom_range(0, 5)); put_ue($urandom_range(0, 5));
      end else put_bits(0, 1);
      if (force_full || $urandom_range(0, 2) != 0) begin
        put_bits(1, 1); put_bits($urandom, 32); put_bits($urandom, 32);
      end else put_bits(0, 1);
      put_bits($urandom, $urandom_range(0, 20));
    end else put_bits(0, 1);
    emit_unit(!force_full && $urandom_range(0, 4) == 0);
  endtask

  // Raw bytes, heavy in zeros so that emulation patterns and long zero runs appear.
  task automatic make_noise(int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b = 8'h00;
        4: b = 8'h03;
        default: b = $urandom_range(0, 255);
      endcase
      byte_q.insert(byte_q.size(), b);
      last_q.insert(last_q.size(), i == len - 1);
    end
  endtask

  task automatic push_byte(logic [7:0] b, bit l);
    byte_q.insert(byte_q.size(), b);
    last_q.insert(last_q.size(), l);
  endtask

  task automatic send_byte(logic [7:0] b, bit l);
    bit at_edge;
    at_edge = 0;
    if (sent < quiet_from && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      nal_ch.valid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
      at_edge = 1;
    end
    if (!at_edge) @(negedge clk);
    nal_ch.valid = 1;
    nal_ch.nal_byte = b;
    nal_ch.last_byte = l;
    do @(posedge clk); while (!nal_ch.ready);
    sent = sent + 1;
  endtask

  always @(posedge clk) begin
    if (rst || (nal_ch.valid && nal_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    res_ch.ready = 0;
    @(negedge clk);
    while (1) begin
      if (!long_hold_done && sent >= 700) begin
        // Long receiver hold-off so the input queue fills and backs up.
        long_hold_done = 1;
        res_ch.ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (sent < quiet_from && $urandom_range(0, 9) == 0) begin
        res_ch.ready = 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        res_ch.ready = 1;
        @(negedge clk);
      end
    end
  end

  initial begin
    nal_ch.valid = 0;
    nal_ch.nal_byte = 0;
    nal_ch.last_byte = 0;
    // Empty unit, a unit cut inside the header, and an emulation pattern.
    push_byte(8'h67, 1);
    push_byte(8'hFF, 0); push_byte(8'h64, 0); push_byte(8'h00, 1);
    push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h03, 0);
    push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 1);
    make_sps(1);
    while (byte_q.size() < NUM_BYTES) begin
      if ($urandom_range(0, 6) == 0) make_noise($urandom_range(1, 30));
      else make_sps(0);
    end
    total = byte_q.size();
    quiet_from = total - total / 10;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    while (byte_q.size() != 0) send_byte(byte_q.pop_front(), last_q.pop_front());
    @(negedge clk);
    nal_ch.valid = 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/sps_pkg.sv
rtl/sps_in_if.sv
rtl/sps_out_if.sv
rtl/sps_fifo.sv
rtl/sps_front.sv
rtl/sps_back.sv
rtl/h264_sps_header_parser.sv
tb/sv/sps_result_checker.sv
tb/sv/h264_sps_header_parser_tb.sv
